FILE: hdl/olr_pkg.sv
// shared types, constants and sigmoid table builder for the online logistic regression block
// no dependencies; every other file imports this package
package olr_pkg;

	// default sizes handed to the top level
	localparam int WEIGHT_BITS_DEF     = 32;
	localparam int SIGMOID_ENTRIES_DEF = 256;

	// fixed widths
	localparam int FEATURE_COUNT = 14;
	localparam int FEAT_W        = 26;
	localparam int PROB_W        = 17;
	localparam int RATE_W        = 16;
	localparam int LE_W          = 35;
	localparam int NUM_W         = 32;
	localparam int CNT_W         = 32;
	localparam int Z_W           = 20;

	// pipeline depth of the constant dividers
	localparam int DIV_STAGES = 3;

	// constant divisors of the feature scaling
	localparam int DIV_LATENCY = 1000;
	localparam int DIV_DISPLAY = 5000;
	localparam int DIV_TOKENS  = 100;
	localparam int DIV_LINES   = 10;
	localparam int DIV_CONTEXT = 1000;
	localparam int DIV_PERPLEX = 100;
	localparam int DIV_CHARS   = 200;

	// request codes
	localparam logic [1:0] REQ_PREDICT = 2'd0;
	localparam logic [1:0] REQ_REJECT  = 2'd1;
	localparam logic [1:0] REQ_ACCEPT  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_LEARNING_RATE  = 2'd0;
	localparam logic [1:0] CFG_L2_STRENGTH    = 2'd1;
	localparam logic [1:0] CFG_SHOW_THRESHOLD = 2'd2;

	localparam logic [RATE_W-1:0] LR_RESET  = 16'd655;
	localparam logic [RATE_W-1:0] L2_RESET  = 16'd66;
	localparam logic [PROB_W-1:0] THR_RESET = 17'd32768;

	localparam logic [PROB_W-1:0] PROB_HALF = 17'd32768;
	localparam logic [PROB_W-1:0] PROB_ONE  = 17'd65536;

	// feature constants in Q10.16
	localparam logic signed [FEAT_W-1:0] FEAT_ONE     = FEAT_W'(65536);
	localparam logic signed [FEAT_W-1:0] FEAT_LP_BIAS = FEAT_W'(327680);

	localparam logic [63:0] ONE30 = 64'h0000_0000_4000_0000;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [15:0]        latency_ms;
		logic [15:0]        display_ms;
		logic [11:0]        token_count;
		logic [9:0]         line_count;
		logic [15:0]        context_tokens;
		logic [7:0]         indent_level;
		logic [3:0]         flag_bits;
		logic [15:0]        perplexity_q8;
		logic signed [15:0] mean_logprob_q12;
		logic [16:0]        top_prob_q16;
		logic [15:0]        char_count;
	} evt_beat_t;

	typedef struct packed {
		logic [PROB_W-1:0] probability;
		logic              predicted_accept;
		logic              show_flag;
		logic              label_matched;
		logic [CNT_W-1:0]  correct_total;
		logic [CNT_W-1:0]  seen_total;
	} res_beat_t;

	typedef struct packed {
		logic prod_en;
		logic grad_en;
		logic write_en;
	} lane_ctl_t;

	typedef struct packed {
		logic acc_clr;
		logic acc_add;
		logic look;
		logic upd;
		logic bias_wr;
		logic train;
		logic label;
	} merge_ctl_t;

	// long division by shift and subtract, used only while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int k = 63; k >= 0; k--) begin
			rem = {rem[63:0], num[k]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[k] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(-r) for r in [0,1], Q30 in and out
	function automatic logic [63:0] exp_neg_q30(input logic [63:0] r);
		logic [63:0] term;
		logic [63:0] sum;
		sum  = ONE30;
		term = ONE30;
		for (int k = 1; k <= 24; k++) begin
			term = udiv64((term * r) >> 30, 64'(k));
			if (k[0]) sum = sum - term;
			else sum = sum + term;
		end
		return sum;
	endfunction

	// sigmoid of bin midpoint, Q0.16
	function automatic logic [PROB_W-1:0] sig_entry(input int idx, input int entries);
		logic [63:0] e1;
		logic [63:0] span;
		logic [63:0] mid;
		logic [63:0] mag;
		logic [63:0] whole;
		logic [63:0] e;
		logic [63:0] den;
		logic        neg;
		e1    = exp_neg_q30(ONE30);
		span  = ONE30 << 3;
		mid   = udiv64((64'(idx) * 64'd2 + 64'd1) * span, 64'(entries));
		neg   = (mid < span);
		mag   = neg ? (span - mid) : (mid - span);
		whole = mag >> 30;
		e     = exp_neg_q30(mag & (ONE30 - 64'd1));
		for (int j = 0; j < 16; j++) begin
			if (64'(j) < whole) e = (e * e1) >> 30;
		end
		den = ONE30 + e;
		if (neg) return PROB_W'(udiv64((e << 16) + (den >> 1), den));
		return PROB_W'(udiv64((ONE30 << 16) + (den >> 1), den));
	endfunction

endpackage

FILE: hdl/olr_ifs.sv
// channel interfaces: event input, result output, configuration write
// depends on olr_pkg for the beat types
interface olr_evt_if import olr_pkg::*; ();
	logic      valid;
	logic      ready;
	evt_beat_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface olr_res_if import olr_pkg::*; ();
	logic      valid;
	logic      ready;
	res_beat_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface olr_cfg_if import olr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        index;
	logic [PROB_W-1:0] value;
	modport source(output valid, output index, output value, input ready);
	modport sink(input valid, input index, input value, output ready);
endinterface

FILE: hdl/online_logistic_regression.sv
// top level: event capture, feature dividers, 14 lanes, merge stage, sequencer
// depends on olr_pkg, olr_ifs, olr_div, olr_lane, olr_merge
//
// channel  dir  beat
// evt      in   one completion event (request type and raw measurements)
// res      out  probability, decisions and accuracy counters
// cfg      in   register index and value (learning rate, l2 strength, threshold)
//
// each event passes through the pipelined constant dividers that scale the features,
// then the merge adding one lane product per cycle, then lookup, update and result
// hand-off; a new event is accepted only once the sequencer is back in idle.
// the result sits in an output register; a stalled result holds the sequencer
// in its last step. reset clears weights, bias, counters, sequencer, result valid and configuration at once.
module online_logistic_regression import olr_pkg::*; #(
	parameter int WEIGHT_BITS     = WEIGHT_BITS_DEF,
	parameter int SIGMOID_ENTRIES = SIGMOID_ENTRIES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	olr_evt_if.sink   evt,
	olr_res_if.source res,
	olr_cfg_if.sink   cfg
);
	localparam int PROD_W = WEIGHT_BITS + FEAT_W - 16;
	localparam int LIDX_W = $clog2(FEATURE_COUNT);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIV   = 4'd1;
	localparam logic [3:0] ST_MUL   = 4'd2;
	localparam logic [3:0] ST_ACC   = 4'd3;
	localparam logic [3:0] ST_LOOK  = 4'd4;
	localparam logic [3:0] ST_UPD   = 4'd5;
	localparam logic [3:0] ST_GRAD  = 4'd6;
	localparam logic [3:0] ST_WRITE = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0]               state_q;
	logic [4:0]               cnt_q;
	evt_beat_t                evt_q;
	logic                     evt_acc;
	logic                     train;
	logic [RATE_W-1:0]        lr_q;
	logic [RATE_W-1:0]        l2_q;
	logic [PROB_W-1:0]        thr_q;
	logic [NUM_W-1:0]         quo [7];
	logic signed [FEAT_W-1:0] feat [FEATURE_COUNT];
	logic signed [PROD_W-1:0] lane_prod [FEATURE_COUNT];
	logic signed [LE_W-1:0]   lr_err;
	logic [RATE_W-1:0]        decay;
	lane_ctl_t                lane_ctl;
	merge_ctl_t               merge_ctl;
	res_beat_t                result;
	res_beat_t                res_q;
	logic                     res_valid_q;

	assign evt.ready = (state_q == ST_IDLE);
	assign evt_acc   = evt.valid && evt.ready;
	assign train     = (evt_q.req_type == REQ_REJECT) || (evt_q.req_type == REQ_ACCEPT);

	// feature dividers, loaded straight from the accepted beat
	olr_div #(.DIVISOR(DIV_LATENCY)) u_div_lat (.clk, .start(evt_acc),
		.num({evt.data.latency_ms, 16'd0} + 32'd500), .quo(quo[0]));
	olr_div #(.DIVISOR(DIV_DISPLAY)) u_div_disp (.clk, .start(evt_acc),
		.num({evt.data.display_ms, 16'd0} + 32'd2500), .quo(quo[1]));
	olr_div #(.DIVISOR(DIV_TOKENS)) u_div_tok (.clk, .start(evt_acc),
		.num({4'd0, evt.data.token_count, 16'd0} + 32'd50), .quo(quo[2]));
	olr_div #(.DIVISOR(DIV_LINES)) u_div_line (.clk, .start(evt_acc),
		.num({6'd0, evt.data.line_count, 16'd0} + 32'd5), .quo(quo[3]));
	olr_div #(.DIVISOR(DIV_CONTEXT)) u_div_ctx (.clk, .start(evt_acc),
		.num({evt.data.context_tokens, 16'd0} + 32'd500), .quo(quo[4]));
	olr_div #(.DIVISOR(DIV_PERPLEX)) u_div_ppl (.clk, .start(evt_acc),
		.num({8'd0, evt.data.perplexity_q8, 8'd0} + 32'd50), .quo(quo[5]));
	olr_div #(.DIVISOR(DIV_CHARS)) u_div_chr (.clk, .start(evt_acc),
		.num({evt.data.char_count, 16'd0} + 32'd100), .quo(quo[6]));

	// feature vector in Q10.16
	always_comb begin
		feat[0]  = $signed(quo[0][FEAT_W-1:0]);
		feat[1]  = $signed(quo[1][FEAT_W-1:0]);
		feat[2]  = $signed(quo[2][FEAT_W-1:0]);
		feat[3]  = $signed(quo[3][FEAT_W-1:0]);
		feat[4]  = $signed(quo[4][FEAT_W-1:0]);
		feat[5]  = $signed({5'd0, evt_q.indent_level, 13'd0});
		feat[6]  = evt_q.flag_bits[0] ? FEAT_ONE : '0;
		feat[7]  = evt_q.flag_bits[1] ? FEAT_ONE : '0;
		feat[8]  = evt_q.flag_bits[2] ? FEAT_ONE : '0;
		feat[9]  = $signed(quo[5][FEAT_W-1:0]);
		feat[10] = (FEAT_W'($signed(evt_q.mean_logprob_q12)) <<< 4) + FEAT_LP_BIAS;
		feat[11] = (evt_q.top_prob_q16 > PROB_ONE) ? FEAT_ONE
			: $signed({9'd0, evt_q.top_prob_q16});
		feat[12] = evt_q.flag_bits[3] ? FEAT_ONE : '0;
		feat[13] = $signed(quo[6][FEAT_W-1:0]);
	end

	// lane and merge controls
	always_comb begin
		lane_ctl.prod_en   = (state_q == ST_MUL);
		lane_ctl.grad_en   = (state_q == ST_GRAD) && train;
		lane_ctl.write_en  = (state_q == ST_WRITE) && train;
		merge_ctl.acc_clr  = (state_q == ST_MUL);
		merge_ctl.acc_add  = (state_q == ST_ACC);
		merge_ctl.look     = (state_q == ST_LOOK);
		merge_ctl.upd      = (state_q == ST_UPD);
		merge_ctl.bias_wr  = (state_q == ST_GRAD) && train;
		merge_ctl.train    = train;
		merge_ctl.label    = (evt_q.req_type == REQ_ACCEPT);
	end

	for (genvar g = 0; g < FEATURE_COUNT; g++) begin : g_lane
		olr_lane #(.WEIGHT_BITS(WEIGHT_BITS)) u_lane (
			.clk, .arst_n, .ctl(lane_ctl), .feature(feat[g]),
			.lr_err, .decay, .prod(lane_prod[g]));
	end

	olr_merge #(.WEIGHT_BITS(WEIGHT_BITS), .SIGMOID_ENTRIES(SIGMOID_ENTRIES)) u_merge (
		.clk, .arst_n, .ctl(merge_ctl), .lane_prod(lane_prod[cnt_q[LIDX_W-1:0]]),
		.lr(lr_q), .l2(l2_q), .thr(thr_q), .lr_err, .decay, .result);

	// event beat and result capture
	always_ff @(posedge clk) begin
		if (evt_acc) evt_q <= evt.data;
		if (state_q == ST_DONE && (!res_valid_q || res.ready)) res_q <= result;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (evt_acc) state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(DIV_STAGES - 1)) state_q <= ST_MUL;
				end
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(FEATURE_COUNT - 1)) state_q <= ST_LOOK;
				end
				ST_LOOK:  state_q <= ST_UPD;
				ST_UPD:   state_q <= ST_GRAD;
				ST_GRAD:  state_q <= ST_WRITE;
				ST_WRITE: state_q <= ST_DONE;
				ST_DONE: begin
					if (!res_valid_q || res.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!res_valid_q || res.ready)) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= LR_RESET;
			l2_q  <= L2_RESET;
			thr_q <= THR_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_LEARNING_RATE:  lr_q  <= cfg.value[RATE_W-1:0];
				CFG_L2_STRENGTH:    l2_q  <= cfg.value[RATE_W-1:0];
				CFG_SHOW_THRESHOLD: thr_q <= cfg.value;
				default: ;
			endcase
		end
	end
endmodule

FILE: hdl/olr_div.sv
// divider by a constant through reciprocal multiplication, three pipeline stages
// depends on olr_pkg for the numerator width
module olr_div import olr_pkg::*; #(
	parameter int DIVISOR = 10
) (
	input  logic             clk,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	output logic [NUM_W-1:0] quo
);
	localparam int HALF_W  = NUM_W / 2;
	localparam int DIV_LOG = $clog2(DIVISOR);
	localparam int REM_W   = (DIV_LOG > 0) ? DIV_LOG : 1;
	localparam int K1      = HALF_W + DIV_LOG;
	localparam int K2      = HALF_W + 2 * DIV_LOG;
	localparam int M1_W    = HALF_W + 1;
	localparam int M2_W    = HALF_W + DIV_LOG + 1;
	localparam int N2_W    = HALF_W + REM_W;
	localparam int P1_W    = HALF_W + M1_W;
	localparam int P2_W    = N2_W + M2_W;
	localparam logic [M1_W-1:0] M1 =
		M1_W'(((64'd1 << K1) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
	localparam logic [M2_W-1:0] M2 =
		M2_W'(((64'd1 << K2) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
	localparam logic [HALF_W-1:0] DIV_C = HALF_W'(DIVISOR);

	logic [NUM_W-1:0]  num_q;
	logic [P1_W-1:0]   p1;
	logic [HALF_W-1:0] r1;
	logic [P2_W-1:0]   p2;
	logic [HALF_W-1:0] hi_s1;
	logic [HALF_W-1:0] lo_s1;
	logic [HALF_W-1:0] q1_s1;
	logic [HALF_W-1:0] q1_s2;
	logic [N2_W-1:0]   n2_s2;
	logic [HALF_W-1:0] q1_s3;
	logic [HALF_W-1:0] q2_s3;

	// upper half quotient, its remainder joined to the lower half, lower quotient
	always_comb begin
		p1 = P1_W'(num_q[NUM_W-1:HALF_W]) * P1_W'(M1);
		r1 = hi_s1 - q1_s1 * DIV_C;
		p2 = P2_W'(n2_s2) * P2_W'(M2);
	end

	// numerator held from the accepted beat, stages run every cycle
	always_ff @(posedge clk) begin
		if (start) num_q <= num;
		hi_s1 <= num_q[NUM_W-1:HALF_W];
		lo_s1 <= num_q[HALF_W-1:0];
		q1_s1 <= HALF_W'(p1 >> K1);
		q1_s2 <= q1_s1;
		n2_s2 <= {REM_W'(r1), lo_s1};
		q1_s3 <= q1_s2;
		q2_s3 <= HALF_W'(p2 >> K2);
	end

	assign quo = {q1_s3, q2_s3};
endmodule

FILE: hdl/olr_lane.sv
// one feature lane: weight register, weight times feature product, sgd update
// depends on olr_pkg for widths and the lane control struct
module olr_lane import olr_pkg::*; #(
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
	localparam int PROD_W = WEIGHT_BITS + FEAT_W - 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lane_ctl_t                ctl,
	input  logic signed [FEAT_W-1:0] feature,
	input  logic signed [LE_W-1:0]   lr_err,
	input  logic [RATE_W-1:0]        decay,
	output logic signed [PROD_W-1:0] prod
);
	localparam int MUL_W = WEIGHT_BITS + FEAT_W;
	localparam int GF_W  = LE_W + FEAT_W;
	localparam int G_W   = GF_W - 32;
	localparam int DC_W  = WEIGHT_BITS + RATE_W + 1;
	localparam int D_W   = DC_W - 16;
	localparam int NW    = WEIGHT_BITS + G_W + 2;
	localparam logic signed [GF_W-1:0] GRAD_HALF = GF_W'(64'h8000_0000);
	localparam logic signed [DC_W-1:0] DEC_HALF  = DC_W'(32'h8000);
	localparam logic signed [NW-1:0] W_MAX =
		{{(NW - WEIGHT_BITS + 1){1'b0}}, {(WEIGHT_BITS - 1){1'b1}}};
	localparam logic signed [NW-1:0] W_MIN =
		{{(NW - WEIGHT_BITS + 1){1'b1}}, {(WEIGHT_BITS - 1){1'b0}}};

	logic signed [WEIGHT_BITS-1:0] weight_q;
	logic signed [MUL_W-1:0]       mul_full;
	logic signed [GF_W-1:0]        grad_rnd;
	logic signed [DC_W-1:0]        dec_rnd;
	logic signed [G_W-1:0]         grad_s1;
	logic signed [D_W-1:0]         dec_s1;
	logic signed [NW-1:0]          w_next;
	logic signed [WEIGHT_BITS-1:0] w_sat;

	// products, the gradient and decay ones with round-half-up offsets, and the saturated new weight
	always_comb begin
		mul_full = weight_q * feature;
		grad_rnd = lr_err * feature + GRAD_HALF;
		dec_rnd  = $signed({1'b0, decay}) * weight_q + DEC_HALF;
		w_next   = NW'(weight_q) - NW'(grad_s1) - NW'(dec_s1);
		if (w_next > W_MAX) w_sat = WEIGHT_BITS'(W_MAX);
		else if (w_next < W_MIN) w_sat = WEIGHT_BITS'(W_MIN);
		else w_sat = WEIGHT_BITS'(w_next);
	end

	// product and gradient terms
	always_ff @(posedge clk) begin
		if (ctl.prod_en) prod <= PROD_W'(mul_full >>> 16);
		if (ctl.grad_en) begin
			grad_s1 <= G_W'(grad_rnd >>> 32);
			dec_s1  <= D_W'(dec_rnd >>> 16);
		end
	end

	// weight write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= '0;
		end else if (ctl.write_en) begin
			weight_q <= w_sat;
		end
	end
endmodule

FILE: hdl/olr_merge.sv
// merge stage: sums lane products with the bias, sigmoid lookup, bias update, counters
// depends on olr_pkg for widths, control struct, result beat and the table builder
module olr_merge import olr_pkg::*; #(
	parameter int WEIGHT_BITS     = WEIGHT_BITS_DEF,
	parameter int SIGMOID_ENTRIES = SIGMOID_ENTRIES_DEF,
	localparam int PROD_W = WEIGHT_BITS + FEAT_W - 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  merge_ctl_t               ctl,
	input  logic signed [PROD_W-1:0] lane_prod,
	input  logic [RATE_W-1:0]        lr,
	input  logic [RATE_W-1:0]        l2,
	input  logic [PROB_W-1:0]        thr,
	output logic signed [LE_W-1:0]   lr_err,
	output logic [RATE_W-1:0]        decay,
	output res_beat_t                result
);
	localparam int ACC_W = PROD_W + 5;
	localparam int IDX_W = $clog2(SIGMOID_ENTRIES);
	localparam int B_W   = LE_W - 16;
	localparam int NW    = WEIGHT_BITS + 2;
	localparam logic signed [ACC_W-1:0] Z_LO = {{(ACC_W - Z_W + 1){1'b1}}, {(Z_W - 1){1'b0}}};
	localparam logic signed [ACC_W-1:0] Z_HI = {{(ACC_W - Z_W + 1){1'b0}}, {(Z_W - 1){1'b1}}};
	localparam logic signed [LE_W-1:0]  LE_HALF = LE_W'(32'h8000);
	localparam logic signed [NW-1:0] W_MAX =
		{{(NW - WEIGHT_BITS + 1){1'b0}}, {(WEIGHT_BITS - 1){1'b1}}};
	localparam logic signed [NW-1:0] W_MIN =
		{{(NW - WEIGHT_BITS + 1){1'b1}}, {(WEIGHT_BITS - 1){1'b0}}};

	logic signed [ACC_W-1:0]       acc_q;
	logic signed [WEIGHT_BITS-1:0] bias_q;
	logic signed [Z_W-1:0]         z_cl;
	logic [IDX_W-1:0]              idx;
	logic [PROB_W-1:0]             rom_w [SIGMOID_ENTRIES];
	logic [PROB_W-1:0]             p_q;
	logic signed [PROB_W:0]        err;
	logic signed [LE_W-1:0]        le_q;
	logic [RATE_W-1:0]             decay_q;
	logic [2*RATE_W-1:0]           lr_l2;
	logic signed [LE_W-1:0]        le_rnd;
	logic signed [NW-1:0]          b_next;
	logic signed [WEIGHT_BITS-1:0] b_sat;
	logic                          pred_one;
	logic                          matched_q;
	logic [CNT_W-1:0]              correct_q;
	logic [CNT_W-1:0]              seen_q;

	// sigmoid table as constant logic
	for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_rom
		localparam logic [PROB_W-1:0] ENTRY = sig_entry(g, SIGMOID_ENTRIES);
		assign rom_w[g] = ENTRY;
	end

	// clamp z and form the table index, prediction, error and saturated bias update
	always_comb begin
		if (acc_q < Z_LO) z_cl = Z_W'(Z_LO);
		else if (acc_q > Z_HI) z_cl = Z_W'(Z_HI);
		else z_cl = Z_W'(acc_q);
		idx      = {~z_cl[Z_W-1], z_cl[Z_W-2 -: IDX_W - 1]};
		pred_one = (p_q >= PROB_HALF);
		err      = $signed({1'b0, p_q}) - (ctl.label ? $signed({1'b0, PROB_ONE}) : '0);
		lr_l2    = lr * l2;
		le_rnd   = le_q + LE_HALF;
		b_next   = NW'(bias_q) - NW'(B_W'(le_rnd >>> 16));
		if (b_next > W_MAX) b_sat = WEIGHT_BITS'(W_MAX);
		else if (b_next < W_MIN) b_sat = WEIGHT_BITS'(W_MIN);
		else b_sat = WEIGHT_BITS'(b_next);
	end

	// accumulator, lookup and update terms
	always_ff @(posedge clk) begin
		if (ctl.acc_clr) acc_q <= ACC_W'(bias_q);
		else if (ctl.acc_add) acc_q <= acc_q + ACC_W'(lane_prod);
		if (ctl.look) p_q <= rom_w[idx];
		if (ctl.upd) begin
			le_q    <= $signed({1'b0, lr}) * err;
			decay_q <= lr_l2[2*RATE_W-1:RATE_W];
		end
	end

	// bias and accuracy counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q    <= '0;
			matched_q <= 1'b0;
			correct_q <= '0;
			seen_q    <= '0;
		end else begin
			if (ctl.bias_wr) bias_q <= b_sat;
			if (ctl.upd) begin
				matched_q <= ctl.train && (pred_one == ctl.label);
				if (ctl.train) begin
					if (pred_one == ctl.label && correct_q != '1) correct_q <= correct_q + 1'b1;
					if (seen_q != '1) seen_q <= seen_q + 1'b1;
				end
			end
		end
	end

	assign lr_err = le_q;
	assign decay  = decay_q;

	always_comb begin
		result.probability      = p_q;
		result.predicted_accept = pred_one;
		result.show_flag        = (p_q >= thr);
		result.label_matched    = matched_q;
		result.correct_total    = correct_q;
		result.seen_total       = seen_q;
	end

`ifndef SYNTHESIS
	a_correct_le_seen: assert property (@(posedge clk) disable iff (!arst_n)
		correct_q <= seen_q) else $error("correct count above seen count");
	a_seen_step: assert property (@(posedge clk) disable iff (!arst_n)
		(seen_q == $past(seen_q)) || (seen_q == $past(seen_q) + 32'd1))
		else $error("seen count moved by more than one");
	a_seen_only_train: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.upd && ctl.train) |=> $stable(seen_q) && $stable(correct_q))
		else $error("counter changed outside a train update");
`endif
endmodule
